// ----- hw/rtl/mse_pkg.sv -----
// mse_pkg: shared constants, codes and types of the instruction executor
// with row buffer timing; no dependencies
package mse_pkg;

	localparam int MEM_BYTES  = 65536;
	localparam int ROW_BYTES  = 1024;
	localparam int MEM_AW     = $clog2(MEM_BYTES);
	localparam int BANK_DEPTH = MEM_BYTES / 4;
	localparam int BANK_AW    = $clog2(BANK_DEPTH);
	localparam int ROW_AW     = $clog2(ROW_BYTES);
	localparam int ROW_W      = MEM_AW - ROW_AW;

	localparam int NUM_REGS   = 32;
	localparam int REG_AW     = 5;
	localparam int XLEN       = 32;
	localparam int ADDR_SUM_W = XLEN + 2;
	localparam int PC_W       = 10;
	localparam int PEND_W     = 11;
	localparam int DLY_W      = 10;
	localparam int BASE_W     = 16;
	localparam int LAT_W      = 12;
	localparam int MODE_W     = 4;
	localparam int STATUS_W   = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [DLY_W-1:0]  ROW_DELAY_RST   = DLY_W'(10);
	localparam logic [DLY_W-1:0]  COL_DELAY_RST   = DLY_W'(2);
	localparam logic [BASE_W-1:0] DATA_BASE_RST   = BASE_W'(1000);
	localparam logic [PEND_W-1:0] PROGRAM_END_RST = PEND_W'(0);

	typedef enum logic [MODE_W-1:0] {
		MODE_ADD  = 4'd0,
		MODE_SUB  = 4'd1,
		MODE_MUL  = 4'd2,
		MODE_SLT  = 4'd3,
		MODE_ADDI = 4'd4,
		MODE_BEQ  = 4'd5,
		MODE_BNE  = 4'd6,
		MODE_J    = 4'd7,
		MODE_LW   = 4'd8,
		MODE_SW   = 4'd9
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK         = 2'd0,
		ST_BAD_TARGET = 2'd1,
		ST_BAD_ADDR   = 2'd2
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ROW_DELAY   = 2'd0,
		CFG_COL_DELAY   = 2'd1,
		CFG_DATA_BASE   = 2'd2,
		CFG_PROGRAM_END = 2'd3
	} cfg_idx_t;

endpackage

// ----- hw/rtl/mse_if.sv -----
// mse_req_if and mse_rsp_if: valid/ready channels for instructions and results
// depends on mse_pkg
interface mse_req_if;
	import mse_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [MODE_W-1:0]        mode;
	logic [REG_AW-1:0]        dest_reg;
	logic [REG_AW-1:0]        src_a;
	logic [REG_AW-1:0]        src_b;
	logic signed [XLEN-1:0]   immediate;
	logic [PC_W-1:0]          target_address;

	modport source (output valid, mode, dest_reg, src_a, src_b, immediate, target_address,
		input ready);
	modport sink (input valid, mode, dest_reg, src_a, src_b, immediate, target_address,
		output ready);
endinterface

interface mse_rsp_if;
	import mse_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [PC_W-1:0]     next_pc;
	logic                branch_taken;
	logic                write_enable;
	logic [XLEN-1:0]     write_value;
	logic [LAT_W-1:0]    access_latency;

	modport source (output valid, status, next_pc, branch_taken, write_enable, write_value,
		access_latency, input ready);
	modport sink (input valid, status, next_pc, branch_taken, write_enable, write_value,
		access_latency, output ready);
endinterface

// ----- hw/rtl/mse_ram.sv -----
// mse_ram: generic single write port, single read port ram with registered read
// no dependencies
module mse_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- hw/rtl/mips_subset_exec_with_row_buffer.sv -----
// mips_subset_exec_with_row_buffer: top level, executes one decoded instruction per request
// depends on mse_pkg, mse_req_if, mse_rsp_if and mse_ram
//
// Executes add, sub, mul, slt, addi, beq, bne, j, lw and sw against a 32-entry register file
// held in two ram copies and a byte memory held in four byte-wide banks, and reports the
// DRAM latency of each load or store from an open-row model. A request passes the register
// file read and then the data memory read before its result is shown in the result stage. A new
// request is taken every cycle as long as results are being taken; register values are
// forwarded from the result stage and from the last write, so dependent requests do not wait.
// After reset the data memory is cleared one row of four bytes per cycle; requests are held off
// meanwhile, configuration writes are taken.
module mips_subset_exec_with_row_buffer (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [mse_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [mse_pkg::CFG_DATA_W-1:0] cfg_data,
	mse_req_if.sink                        req,
	mse_rsp_if.source                      rsp
);
	import mse_pkg::*;

	localparam logic signed [ADDR_SUM_W-1:0] ADDR_MAX = ADDR_SUM_W'(MEM_BYTES - 4);

	logic [DLY_W-1:0]  row_delay_q;
	logic [DLY_W-1:0]  col_delay_q;
	logic [BASE_W-1:0] data_base_q;
	logic [PEND_W-1:0] program_end_q;

	logic               clr_busy_q;
	logic [BANK_AW-1:0] clr_idx_q;

	logic accept;
	logic s1_adv;
	logic out_take;

	logic              s1_vld_q;
	logic [MODE_W-1:0] mode_s1;
	logic [REG_AW-1:0] dst_s1;
	logic [REG_AW-1:0] srca_s1;
	logic [REG_AW-1:0] srcb_s1;
	logic [XLEN-1:0]   imm_s1;
	logic [PC_W-1:0]   tgt_s1;

	logic                s2_vld_q;
	logic [STATUS_W-1:0] st_s2;
	logic [PC_W-1:0]     nxt_s2;
	logic                tk_s2;
	logic                we_s2;
	logic [XLEN-1:0]     wv_s2;
	logic [LAT_W-1:0]    lat_s2;
	logic                lw_s2;
	logic [REG_AW-1:0]   dst_s2;
	logic [1:0]          lo_s2;

	logic [PC_W-1:0]  pc_q;
	logic             row_open_q;
	logic [ROW_W-1:0] open_row_q;

	logic [NUM_REGS-1:0] rf_vld_q;
	logic                w_vld_q;
	logic [REG_AW-1:0]   w_idx_q;
	logic [XLEN-1:0]     w_data_q;

	logic [REG_AW-1:0] rb_raddr;
	logic [REG_AW-1:0] rb_idx_s1;
	logic [XLEN-1:0]   rf_a_rd;
	logic [XLEN-1:0]   rf_b_rd;
	logic              rf_we;

	logic [XLEN-1:0] ld_val;
	logic [XLEN-1:0] s2_val;
	logic [XLEN-1:0] opa;
	logic [XLEN-1:0] opb;
	logic [XLEN-1:0] prod;

	logic [PC_W-1:0]              next_seq;
	logic signed [ADDR_SUM_W-1:0] addr_sum;
	logic signed [ADDR_SUM_W-1:0] base_ext;
	logic                         addr_bad;
	logic                         tgt_bad;
	logic [MEM_AW-1:0]            ad;
	logic [ROW_W-1:0]             row;
	logic [LAT_W-1:0]             lat_calc;

	logic [STATUS_W-1:0] st;
	logic [PC_W-1:0]     nxt;
	logic                tk;
	logic                wr;
	logic [XLEN-1:0]     val;
	logic [LAT_W-1:0]    lat;
	logic                is_mem;
	logic                is_lw;
	logic                is_sw;
	logic                we1;

	logic               bank_we    [4];
	logic [BANK_AW-1:0] bank_idx   [4];
	logic [BANK_AW-1:0] bank_waddr [4];
	logic [7:0]         bank_wdata [4];
	logic [7:0]         bank_rdata [4];

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_delay_q   <= ROW_DELAY_RST;
			col_delay_q   <= COL_DELAY_RST;
			data_base_q   <= DATA_BASE_RST;
			program_end_q <= PROGRAM_END_RST;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_idx))
				CFG_ROW_DELAY:   row_delay_q   <= cfg_data[DLY_W-1:0];
				CFG_COL_DELAY:   col_delay_q   <= cfg_data[DLY_W-1:0];
				CFG_DATA_BASE:   data_base_q   <= cfg_data[BASE_W-1:0];
				CFG_PROGRAM_END: program_end_q <= cfg_data[PEND_W-1:0];
				default: ;
			endcase
		end
	end

	// memory clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clr_busy_q) begin
			clr_idx_q <= clr_idx_q + BANK_AW'(1);
			if (clr_idx_q == '1) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// handshake
	assign out_take  = rsp.valid & rsp.ready;
	assign s1_adv    = s1_vld_q & (~s2_vld_q | out_take);
	assign req.ready = ~clr_busy_q & (~s1_vld_q | s1_adv);
	assign accept    = req.valid & req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_q <= 1'b0;
		end else if (accept) begin
			s1_vld_q <= 1'b1;
		end else if (s1_adv) begin
			s1_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1 <= req.mode;
			dst_s1  <= req.dest_reg;
			srca_s1 <= req.src_a;
			srcb_s1 <= req.src_b;
			imm_s1  <= req.immediate;
			tgt_s1  <= req.target_address;
		end
	end

	// register file, two read copies
	assign rb_raddr  = (req.mode == MODE_SW) ? req.dest_reg : req.src_b;
	assign rb_idx_s1 = (mode_s1 == MODE_SW) ? dst_s1 : srcb_s1;
	assign rf_we     = out_take & we_s2;

	mse_ram #(.WIDTH(XLEN), .DEPTH(NUM_REGS)) u_rf_a (
		.clk   (clk),
		.we    (rf_we),
		.waddr (dst_s2),
		.wdata (s2_val),
		.re    (accept),
		.raddr (req.src_a),
		.rdata (rf_a_rd)
	);

	mse_ram #(.WIDTH(XLEN), .DEPTH(NUM_REGS)) u_rf_b (
		.clk   (clk),
		.we    (rf_we),
		.waddr (dst_s2),
		.wdata (s2_val),
		.re    (accept),
		.raddr (rb_raddr),
		.rdata (rf_b_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_vld_q <= '0;
			w_vld_q  <= 1'b0;
		end else if (rf_we) begin
			rf_vld_q[dst_s2] <= 1'b1;
			w_vld_q          <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (rf_we) begin
			w_idx_q  <= dst_s2;
			w_data_q <= s2_val;
		end
	end

	// load data from the four banks
	always_comb begin
		for (int j = 0; j < 4; j++) begin
			ld_val[8*j +: 8] = bank_rdata[2'(lo_s2 + 2'(j))];
		end
	end

	assign s2_val = we_s2 ? (lw_s2 ? ld_val : wv_s2) : '0;

	function automatic logic [XLEN-1:0] fwd(input logic [REG_AW-1:0] idx,
		input logic [XLEN-1:0] ram);
		logic [XLEN-1:0] v;
		v = '0;
		if (idx == '0) begin
			v = '0;
		end else if (s2_vld_q && we_s2 && dst_s2 == idx) begin
			v = s2_val;
		end else if (w_vld_q && w_idx_q == idx) begin
			v = w_data_q;
		end else if (rf_vld_q[idx]) begin
			v = ram;
		end
		return v;
	endfunction

	always_comb begin
		opa = fwd(srca_s1, rf_a_rd);
		opb = fwd(rb_idx_s1, rf_b_rd);
	end

	assign prod = opa * opb;

	// address, target and latency
	assign next_seq = pc_q + PC_W'(4);
	assign addr_sum = $signed({{2{opa[XLEN-1]}}, opa}) + $signed({{2{imm_s1[XLEN-1]}}, imm_s1});
	assign base_ext = $signed({{(ADDR_SUM_W-BASE_W){1'b0}}, data_base_q});
	assign addr_bad = (addr_sum < base_ext) || (addr_sum > ADDR_MAX);
	assign tgt_bad  = ({1'b0, tgt_s1} >= program_end_q) || (tgt_s1[1:0] != 2'b00);
	assign ad       = addr_sum[MEM_AW-1:0];
	assign row      = ad[MEM_AW-1:ROW_AW];

	always_comb begin
		if (!row_open_q) begin
			lat_calc = LAT_W'(row_delay_q) + LAT_W'(col_delay_q);
		end else if (open_row_q == row) begin
			lat_calc = LAT_W'(col_delay_q);
		end else begin
			lat_calc = LAT_W'({row_delay_q, 1'b0}) + LAT_W'(col_delay_q);
		end
	end

	// execute
	always_comb begin
		st     = ST_OK;
		nxt    = next_seq;
		tk     = 1'b0;
		wr     = 1'b0;
		val    = '0;
		lat    = '0;
		is_mem = 1'b0;
		is_lw  = 1'b0;
		is_sw  = 1'b0;
		case (mode_t'(mode_s1))
			MODE_ADD: begin
				val = opa + opb;
				wr  = 1'b1;
			end
			MODE_SUB: begin
				val = opa - opb;
				wr  = 1'b1;
			end
			MODE_MUL: begin
				val = prod;
				wr  = 1'b1;
			end
			MODE_SLT: begin
				val = XLEN'($signed(opa) < $signed(opb));
				wr  = 1'b1;
			end
			MODE_ADDI: begin
				val = opa + imm_s1;
				wr  = 1'b1;
			end
			MODE_BEQ, MODE_BNE, MODE_J: begin
				if (tgt_bad) begin
					st  = ST_BAD_TARGET;
					nxt = pc_q;
				end else if ((mode_s1 == MODE_J) || ((mode_s1 == MODE_BEQ) == (opa == opb))) begin
					tk  = 1'b1;
					nxt = tgt_s1;
				end
			end
			MODE_LW, MODE_SW: begin
				if (addr_bad) begin
					st  = ST_BAD_ADDR;
					nxt = pc_q;
				end else begin
					is_mem = 1'b1;
					lat    = lat_calc;
					if (mode_s1 == MODE_LW) begin
						is_lw = 1'b1;
						wr    = 1'b1;
					end else begin
						is_sw = 1'b1;
					end
				end
			end
			default: ;
		endcase
		we1 = wr && (dst_s1 != '0);
	end

	// architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q       <= '0;
			row_open_q <= 1'b0;
			open_row_q <= '0;
		end else if (s1_adv) begin
			pc_q <= nxt;
			if (is_mem) begin
				row_open_q <= 1'b1;
				open_row_q <= row;
			end
		end
	end

	// data memory banks, bank k holds the bytes whose address is k modulo 4
	for (genvar k = 0; k < 4; k++) begin : g_bank
		logic [1:0] sel;

		assign sel           = 2'(k) - ad[1:0];
		assign bank_idx[k]   = ad[MEM_AW-1:2] + BANK_AW'(2'(k) < ad[1:0]);
		assign bank_we[k]    = clr_busy_q | (s1_adv & is_sw);
		assign bank_waddr[k] = clr_busy_q ? clr_idx_q : bank_idx[k];
		assign bank_wdata[k] = clr_busy_q ? 8'h00 : opb[8*sel +: 8];

		mse_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_bank (
			.clk   (clk),
			.we    (bank_we[k]),
			.waddr (bank_waddr[k]),
			.wdata (bank_wdata[k]),
			.re    (s1_adv & is_lw),
			.raddr (bank_idx[k]),
			.rdata (bank_rdata[k])
		);
	end

	// result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_vld_q <= 1'b0;
		end else if (s1_adv) begin
			s2_vld_q <= 1'b1;
		end else if (out_take) begin
			s2_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			st_s2  <= st;
			nxt_s2 <= nxt;
			tk_s2  <= tk;
			we_s2  <= we1;
			wv_s2  <= we1 ? val : '0;
			lat_s2 <= lat;
			lw_s2  <= is_lw;
			dst_s2 <= dst_s1;
			lo_s2  <= ad[1:0];
		end
	end

	assign rsp.valid          = s2_vld_q;
	assign rsp.status         = st_s2;
	assign rsp.next_pc        = nxt_s2;
	assign rsp.branch_taken   = tk_s2;
	assign rsp.write_enable   = we_s2;
	assign rsp.write_value    = s2_val;
	assign rsp.access_latency = lat_s2;

endmodule

// ----- hw/rtl/mse_chk.sv -----
// mse_chk: port-level checks on the result channel of the executor, bound to the top level
// depends on mse_pkg and mips_subset_exec_with_row_buffer
module mse_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic [mse_pkg::STATUS_W-1:0]  rsp_status,
	input logic [mse_pkg::PC_W-1:0]      rsp_next_pc,
	input logic                          rsp_branch_taken,
	input logic                          rsp_write_enable,
	input logic [mse_pkg::XLEN-1:0]      rsp_write_value,
	input logic [mse_pkg::LAT_W-1:0]     rsp_access_latency
);
	import mse_pkg::*;

	// stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
			&& $stable(rsp_next_pc) && $stable(rsp_write_value))
		else $error("result changed while stalled");

	// faulting request leaves no trace
	a_fault_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != ST_OK |-> !rsp_branch_taken && !rsp_write_enable
			&& rsp_access_latency == '0)
		else $error("faulting request reported effects");

	// no write, no value
	a_wv_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_write_enable |-> rsp_write_value == '0)
		else $error("write value without register write");

	// taken branch has OK status, lands on an aligned target and writes no register
	a_taken_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_branch_taken |-> rsp_status == ST_OK && rsp_next_pc[1:0] == 2'b00
			&& !rsp_write_enable)
		else $error("taken branch with bad status or unaligned target");

endmodule

bind mips_subset_exec_with_row_buffer mse_chk u_mse_chk (
	.clk                (clk),
	.arst_n             (arst_n),
	.rsp_valid          (rsp.valid),
	.rsp_ready          (rsp.ready),
	.rsp_status         (rsp.status),
	.rsp_next_pc        (rsp.next_pc),
	.rsp_branch_taken   (rsp.branch_taken),
	.rsp_write_enable   (rsp.write_enable),
	.rsp_write_value    (rsp.write_value),
	.rsp_access_latency (rsp.access_latency)
);
